### rtl/fisheye_to_equirect_point_map_core_defines.svh
// Assertion helpers used by the core RTL file
`ifndef FISHEYE_TO_EQUIRECT_POINT_MAP_CORE_DEFINES_SVH
`define FISHEYE_TO_EQUIRECT_POINT_MAP_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define FEPM_ASSERT_IMP(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define FEPM_ASSERT_NXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/fepm_pkg.sv
package fepm_pkg;

	// input and result items
	typedef struct packed {
		logic signed [23:0] in_x;
		logic signed [23:0] in_y;
	} fepm_in_t;

	typedef struct packed {
		logic [23:0] out_x;
		logic [23:0] out_y;
	} fepm_out_t;

	// configuration register indexes
	typedef enum logic [3:0] {
		REG_CENTER_X    = 4'd0,
		REG_CENTER_Y    = 4'd1,
		REG_INV_FOCAL_X = 4'd2,
		REG_INV_FOCAL_Y = 4'd3,
		REG_DIST_COEFFS = 4'd4,
		REG_THETA_WIN   = 4'd5,
		REG_PHI_WIN     = 4'd6,
		REG_PIX_SCALE   = 4'd7
	} fepm_reg_t;

	// remainder datapath: magnitude of theta - min, up to 2^32 - 1
	localparam int REM_W = 33;

	localparam logic signed [31:0] Q28_ONE = 32'sh1000_0000;
	localparam logic [23:0] OUT_MAX = 24'hFF_FFFF;

	// side data that travels with the remainder
	typedef struct packed {
		logic [31:0] ntc;   // clamped theta window value
		logic [31:0] npc;   // clamped phi window value
		logic        tpos;  // theta span positive
		logic        neg;   // theta - min negative
	} fepm_side_t;

	// saturate to signed 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sh0000_0000_7FFF_FFFF)
			r = 32'sh7FFF_FFFF;
		else if (v < -64'sh0000_0000_8000_0000)
			r = -32'sh8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction

	// offset by minimum and clamp to [0, span]; zero when span not positive
	function automatic logic [31:0] clamp_win(input logic signed [31:0] v,
			input logic signed [31:0] mn, input logic signed [31:0] span);
		logic signed [32:0] n;
		logic [31:0] r;
		n = 33'(v) - 33'(mn);
		if (span <= 32'sd0)
			r = '0;
		else if (n < 33'sd0)
			r = '0;
		else if (n > 33'(span))
			r = span;
		else
			r = n[31:0];
		return r;
	endfunction

endpackage

### rtl/fepm_rem_pipe.sv
// Pipelined restoring remainder: ceil(REM_W / NST) quotient bits per stage
module fepm_rem_pipe import fepm_pkg::*; #(
	parameter int NST = 17
) (
	input  logic                 clk,
	input  logic [NST-1:0]       en,
	input  logic [REM_W-1:0]     m_in,
	input  fepm_side_t           side_in,
	input  logic [30:0]          span,
	output logic [REM_W-1:0]     r_out,
	output fepm_side_t           side_out
);

	localparam int SPS = (REM_W + NST - 1) / NST;

	logic [REM_W-1:0] rem_s  [NST];
	fepm_side_t       side_s [NST];
	logic [REM_W-1:0] rem_nx [NST];

	for (genvar j = 0; j < NST; j++) begin : g_stage
		logic [REM_W-1:0] r_prev;
		fepm_side_t       sd_prev;

		if (j == 0) begin : g_first
			assign r_prev  = m_in;
			assign sd_prev = side_in;
		end else begin : g_next
			assign r_prev  = rem_s[j-1];
			assign sd_prev = side_s[j-1];
		end

		// conditional subtract of span shifted by each bit position
		always_comb begin
			logic [REM_W-1:0] r;
			logic [63:0]      cmp;
			int               bi;
			r = r_prev;
			for (int t = 0; t < SPS; t++) begin
				bi = REM_W - 1 - j * SPS - t;
				if (bi >= 0) begin
					cmp = 64'(span) << bi;
					if (64'(r) >= cmp)
						r = r - cmp[REM_W-1:0];
				end
			end
			rem_nx[j] = r;
		end

		always_ff @(posedge clk) begin
			if (en[j]) begin
				rem_s[j]  <= rem_nx[j];
				side_s[j] <= sd_prev;
			end
		end
	end

	assign r_out    = rem_s[NST-1];
	assign side_out = side_s[NST-1];

endmodule

### rtl/fisheye_to_equirect_point_map_core.sv
// Fisheye to equirectangular point mapper. One keypoint enters per clock
// and one mapped position leaves per clock while the output is not
// stalled. The pipeline has one multiplier or one add-and-saturate per
// stage (normalise, square, four Horner steps, angle scaling), followed by
// a 17-stage remainder pipeline for horizontal wrap, then pixel scaling.
// Every stage holds its own item while the output is stalled, so bubbles
// close up and the input stalls only when all stages are full. Registers
// are written through the configuration port, which is always ready;
// write only while the pipeline is empty.
`include "fisheye_to_equirect_point_map_core_defines.svh"

module fisheye_to_equirect_point_map_core import fepm_pkg::*; #(
	parameter int BORDER_OFFSET = 15
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  fepm_in_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output fepm_out_t   out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	localparam int NR     = 17;
	localparam int K_REM0 = 16;
	localparam int K_SEL  = K_REM0 + NR;
	localparam int K_MUL  = K_SEL + 1;
	localparam int K_OUT  = K_MUL + 1;
	localparam int NS     = K_OUT + 1;
	localparam logic [16:0] BORDER_Q = 17'(BORDER_OFFSET) << 8;

	// configuration registers
	logic [23:0] center_x_q, center_y_q;
	logic [31:0] inv_fx_q, inv_fy_q;
	logic [63:0] coeffs_q, theta_win_q, phi_win_q;
	logic [48:0] pix_scale_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q  <= '0;
			center_y_q  <= '0;
			inv_fx_q    <= '0;
			inv_fy_q    <= '0;
			coeffs_q    <= '0;
			theta_win_q <= '0;
			phi_win_q   <= '0;
			pix_scale_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (fepm_reg_t'(cfg_index))
				REG_CENTER_X:    center_x_q  <= cfg_data[23:0];
				REG_CENTER_Y:    center_y_q  <= cfg_data[23:0];
				REG_INV_FOCAL_X: inv_fx_q    <= cfg_data[31:0];
				REG_INV_FOCAL_Y: inv_fy_q    <= cfg_data[31:0];
				REG_DIST_COEFFS: coeffs_q    <= cfg_data;
				REG_THETA_WIN:   theta_win_q <= cfg_data;
				REG_PHI_WIN:     phi_win_q   <= cfg_data;
				REG_PIX_SCALE:   pix_scale_q <= cfg_data[48:0];
				default: ;
			endcase
		end
	end

	// register fields
	logic signed [31:0] k1q, k2q, k3q, k4q;
	logic signed [31:0] tmin, tspan, pmin, pspan;
	logic [23:0] tscale, pscale;
	logic        wrap;

	assign k1q    = 32'($signed({coeffs_q[15:0], 14'd0}));
	assign k2q    = 32'($signed({coeffs_q[31:16], 14'd0}));
	assign k3q    = 32'($signed({coeffs_q[47:32], 14'd0}));
	assign k4q    = 32'($signed({coeffs_q[63:48], 14'd0}));
	assign tmin   = theta_win_q[31:0];
	assign tspan  = theta_win_q[63:32];
	assign pmin   = phi_win_q[31:0];
	assign pspan  = phi_win_q[63:32];
	assign tscale = pix_scale_q[23:0];
	assign pscale = pix_scale_q[47:24];
	assign wrap   = pix_scale_q[48];

	// per-stage valid and enable; a stage moves when empty or when the next moves
	logic [NS-1:0] v, en;

	assign en[NS-1] = !v[NS-1] || !out_stall;
	for (genvar k = 0; k < NS - 1; k++) begin : g_en
		assign en[k] = !v[k] || en[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v <= '0;
		else begin
			if (en[0])
				v[0] <= in_valid;
			for (int k = 1; k < NS; k++) begin
				if (en[k])
					v[k] <= v[k-1];
			end
		end
	end

	assign in_stall  = !en[0];
	assign out_valid = v[NS-1];

	// s1: subtract lens centre
	logic signed [25:0] dx_s1, dy_s1;
	always_ff @(posedge clk) begin
		if (en[0]) begin
			dx_s1 <= 26'(in_data.in_x) - $signed({2'b0, center_x_q});
			dy_s1 <= 26'(in_data.in_y) - $signed({2'b0, center_y_q});
		end
	end

	// s2: scale by reciprocal focal length
	logic signed [57:0] prx_s2, pry_s2;
	always_ff @(posedge clk) begin
		if (en[1]) begin
			prx_s2 <= dx_s1 * $signed({1'b0, inv_fx_q});
			pry_s2 <= dy_s1 * $signed({1'b0, inv_fy_q});
		end
	end

	// s3: normalised coordinates
	logic signed [31:0] nx_s3, ny_s3;
	always_ff @(posedge clk) begin
		if (en[2]) begin
			nx_s3 <= sat32(64'(prx_s2 >>> 12));
			ny_s3 <= sat32(64'(pry_s2 >>> 12));
		end
	end

	// s4: squares
	logic signed [63:0] sqx_s4, sqy_s4;
	logic signed [31:0] nx_s4, ny_s4;
	always_ff @(posedge clk) begin
		if (en[3]) begin
			sqx_s4 <= nx_s3 * nx_s3;
			sqy_s4 <= ny_s3 * ny_s3;
			nx_s4  <= nx_s3;
			ny_s4  <= ny_s3;
		end
	end

	// s5: r2, squares are non-negative so the shifts are plain
	logic [35:0] r2sum;
	assign r2sum = 36'(sqx_s4[63:28]) + 36'(sqy_s4[63:28]);

	logic signed [31:0] r2_s5, nx_s5, ny_s5;
	always_ff @(posedge clk) begin
		if (en[4]) begin
			r2_s5 <= (r2sum > 36'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : r2sum[31:0];
			nx_s5 <= nx_s4;
			ny_s5 <= ny_s4;
		end
	end

	// s6..s13: Horner steps, multiply then add-and-saturate
	logic signed [63:0] ph_s6, ph_s8, ph_s10, ph_s12;
	logic signed [31:0] a_s7, a_s9, a_s11, rad_s13;
	logic signed [31:0] r2_s6, r2_s7, r2_s8, r2_s9, r2_s10, r2_s11;
	logic signed [31:0] nx_s6, nx_s7, nx_s8, nx_s9, nx_s10, nx_s11, nx_s12, nx_s13;
	logic signed [31:0] ny_s6, ny_s7, ny_s8, ny_s9, ny_s10, ny_s11, ny_s12, ny_s13;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			ph_s6 <= k4q * r2_s5;
			r2_s6 <= r2_s5;
			nx_s6 <= nx_s5;
			ny_s6 <= ny_s5;
		end
		if (en[6]) begin
			a_s7  <= sat32(64'(k3q) + (ph_s6 >>> 28));
			r2_s7 <= r2_s6;
			nx_s7 <= nx_s6;
			ny_s7 <= ny_s6;
		end
		if (en[7]) begin
			ph_s8 <= a_s7 * r2_s7;
			r2_s8 <= r2_s7;
			nx_s8 <= nx_s7;
			ny_s8 <= ny_s7;
		end
		if (en[8]) begin
			a_s9  <= sat32(64'(k2q) + (ph_s8 >>> 28));
			r2_s9 <= r2_s8;
			nx_s9 <= nx_s8;
			ny_s9 <= ny_s8;
		end
		if (en[9]) begin
			ph_s10 <= a_s9 * r2_s9;
			r2_s10 <= r2_s9;
			nx_s10 <= nx_s9;
			ny_s10 <= ny_s9;
		end
		if (en[10]) begin
			a_s11  <= sat32(64'(k1q) + (ph_s10 >>> 28));
			r2_s11 <= r2_s10;
			nx_s11 <= nx_s10;
			ny_s11 <= ny_s10;
		end
		if (en[11]) begin
			ph_s12 <= a_s11 * r2_s11;
			nx_s12 <= nx_s11;
			ny_s12 <= ny_s11;
		end
		if (en[12]) begin
			rad_s13 <= sat32(64'(Q28_ONE) + (ph_s12 >>> 28));
			nx_s13  <= nx_s12;
			ny_s13  <= ny_s12;
		end
	end

	// s14: apply radial factor
	logic signed [63:0] tp_s14, pp_s14;
	always_ff @(posedge clk) begin
		if (en[13]) begin
			tp_s14 <= nx_s13 * rad_s13;
			pp_s14 <= ny_s13 * rad_s13;
		end
	end

	// s15: theta and phi
	logic signed [31:0] theta_s15, phi_s15;
	always_ff @(posedge clk) begin
		if (en[14]) begin
			theta_s15 <= sat32(tp_s14 >>> 28);
			phi_s15   <= sat32(pp_s14 >>> 28);
		end
	end

	// s16: window offsets, clamped forms and remainder operand
	logic signed [32:0] dt;
	assign dt = 33'(theta_s15) - 33'(tmin);

	logic [REM_W-1:0] mag_s16;
	fepm_side_t       side_s16;
	always_ff @(posedge clk) begin
		if (en[15]) begin
			mag_s16       <= dt[32] ? 33'(-dt) : 33'(dt);
			side_s16.neg  <= dt[32];
			side_s16.tpos <= (tspan > 32'sd0);
			side_s16.ntc  <= clamp_win(theta_s15, tmin, tspan);
			side_s16.npc  <= clamp_win(phi_s15, pmin, pspan);
		end
	end

	// wrap remainder of |theta - min| by the span
	logic [REM_W-1:0] rem_r;
	fepm_side_t       rem_side;

	fepm_rem_pipe #(
		.NST(NR)
	) u_rem (
		.clk      (clk),
		.en       (en[K_REM0 +: NR]),
		.m_in     (mag_s16),
		.side_in  (side_s16),
		.span     (tspan[30:0]),
		.r_out    (rem_r),
		.side_out (rem_side)
	);

	// s34: pick wrapped or clamped theta, fold negative remainders
	logic [31:0] nt_sel;
	always_comb begin
		if (!wrap)
			nt_sel = rem_side.ntc;
		else if (!rem_side.tpos)
			nt_sel = '0;
		else if (rem_side.neg && (rem_r != '0))
			nt_sel = tspan - rem_r[31:0];
		else
			nt_sel = rem_r[31:0];
	end

	logic [31:0] nt_s34, np_s34;
	always_ff @(posedge clk) begin
		if (en[K_SEL]) begin
			nt_s34 <= nt_sel;
			np_s34 <= rem_side.npc;
		end
	end

	// s35: pixel scaling, operands are non-negative
	logic [55:0] pxx_s35, pxy_s35;
	always_ff @(posedge clk) begin
		if (en[K_MUL]) begin
			pxx_s35 <= nt_s34 * tscale;
			pxy_s35 <= np_s34 * pscale;
		end
	end

	// s36: add border and saturate
	logic [24:0] sx, sy;
	assign sx = 25'(pxx_s35[55:32]) + 25'(BORDER_Q);
	assign sy = 25'(pxy_s35[55:32]) + 25'(BORDER_Q);

	fepm_out_t out_s36;
	always_ff @(posedge clk) begin
		if (en[K_OUT]) begin
			out_s36.out_x <= sx[24] ? OUT_MAX : sx[23:0];
			out_s36.out_y <= sy[24] ? OUT_MAX : sy[23:0];
		end
	end

	assign out_data = out_s36;

	// checks
	`FEPM_ASSERT_IMP(a_stall_full, clk, arst_n, in_stall, &v, "input stalled with a free stage")
	`FEPM_ASSERT_NXT(a_rem_hold, clk, arst_n, v[K_REM0] && !en[K_REM0], v[K_REM0], "held item lost")
	`FEPM_ASSERT_IMP(a_border, clk, arst_n, out_valid, (out_data.out_x >= 24'(BORDER_Q)) && (out_data.out_y >= 24'(BORDER_Q)), "result below border")

endmodule
